FILE: design/scms_pkg.sv
// shared constants, types and helpers for the staircase matrix search
package scms_pkg;

    localparam int MAX_ROWS    = 16;
    localparam int MAX_COLUMNS = 16;
    localparam int VALUE_WIDTH = 32;

    localparam int DEPTH   = MAX_ROWS * MAX_COLUMNS;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int ROW_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W   = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int ROWC_W  = $clog2(MAX_ROWS + 1);
    localparam int COLC_W  = $clog2(MAX_COLUMNS + 1);

    localparam int CFG_DATA_W = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int FIELD_W    = 32;

    typedef logic [VALUE_WIDTH-1:0] word_t;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 1'b1;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_WALK = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    // sign-extend a 32-bit field and wrap it to the stored word width
    function automatic word_t to_word(input logic [FIELD_W-1:0] v);
        logic [2*FIELD_W-1:0] ext;
        ext = {{FIELD_W{v[FIELD_W-1]}}, v};
        return ext[VALUE_WIDTH-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] addr_of(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
        return ADDR_W'(int'(row) * MAX_COLUMNS + int'(col));
    endfunction

endpackage

FILE: design/scms_in_if.sv
// input channel: command, entry write fields and search target
interface scms_in_if;
    logic                valid;
    logic                ready;
    logic                cmd;
    logic [3:0]          entry_row;
    logic [3:0]          entry_column;
    logic signed [31:0]  entry_value;
    logic signed [31:0]  search_target;

    modport source (output valid, cmd, entry_row, entry_column, entry_value,
                    search_target, input ready);
    modport sink   (input valid, cmd, entry_row, entry_column, entry_value,
                    search_target, output ready);
endinterface

FILE: design/scms_out_if.sv
// result channel: one found flag per search
interface scms_out_if;
    logic valid;
    logic ready;
    logic found;

    modport source (output valid, found, input ready);
    modport sink   (input valid, found, output ready);
endinterface

FILE: design/scms_ram.sv
// generic single-write, single-read ram with registered read data
module scms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: design/staircase_matrix_search.sv
// staircase search over a sorted matrix held in one ram
// a search reads the top-right entry when it is taken, then walks one entry per compare
// until a match or the matrix edge, then goes to done; an empty matrix goes straight to done
// throughput: one search at a time, set by the single ram read port, one compare a cycle
// reset: row and column counts clear to zero, the walker goes idle, no result pending;
// the matrix contents are not cleared and must be written before they are searched
module staircase_matrix_search (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [scms_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [scms_pkg::CFG_DATA_W-1:0]     cfg_data,
    scms_in_if.sink                             item,
    scms_out_if.source                          result
);

    scms_pkg::state_t state_reg, state_next;

    logic [scms_pkg::CFG_DATA_W-1:0] row_count_reg, column_count_reg;
    logic [scms_pkg::ROWC_W-1:0]     r_reg, r_next;
    logic [scms_pkg::COLC_W-1:0]     c_reg, c_next;
    scms_pkg::word_t                 key_reg;
    logic                            hit_reg, hit_next;
    logic                            out_valid_reg;
    logic                            found_reg;

    logic [scms_pkg::ROWC_W-1:0]     rows;
    logic [scms_pkg::COLC_W-1:0]     cols;
    logic                            item_xfer, search_xfer, write_xfer;
    logic                            out_free;
    logic                            equal, greater, walk_end;
    logic [scms_pkg::COLC_W-1:0]     c_dec;
    logic [scms_pkg::COLC_W-1:0]     col_sel;
    logic                            ram_we;
    logic [scms_pkg::ADDR_W-1:0]     waddr, raddr;
    scms_pkg::word_t                 rdata;

    scms_ram #(
        .WIDTH (scms_pkg::VALUE_WIDTH),
        .DEPTH (scms_pkg::DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (waddr),
        .wdata (scms_pkg::to_word(item.entry_value)),
        .raddr (raddr),
        .rdata (rdata)
    );

    // counts above the store size act as the store size
    always_comb
    begin
        rows = ({27'b0, row_count_reg} > 32'(scms_pkg::MAX_ROWS))
             ? scms_pkg::ROWC_W'(scms_pkg::MAX_ROWS)
             : scms_pkg::ROWC_W'(row_count_reg);
        cols = ({27'b0, column_count_reg} > 32'(scms_pkg::MAX_COLUMNS))
             ? scms_pkg::COLC_W'(scms_pkg::MAX_COLUMNS)
             : scms_pkg::COLC_W'(column_count_reg);
    end

    assign item.ready   = (state_reg == scms_pkg::ST_IDLE);
    assign item_xfer    = item.valid && item.ready;
    assign search_xfer  = item_xfer && (item.cmd == scms_pkg::CMD_SEARCH);
    assign write_xfer   = item_xfer && (item.cmd == scms_pkg::CMD_WRITE);
    assign out_free     = !out_valid_reg || result.ready;

    assign ram_we = write_xfer
                 && (32'(item.entry_row) < 32'(scms_pkg::MAX_ROWS))
                 && (32'(item.entry_column) < 32'(scms_pkg::MAX_COLUMNS));
    assign waddr  = scms_pkg::addr_of(scms_pkg::ROW_W'(item.entry_row),
                                      scms_pkg::COL_W'(item.entry_column));

    // rdata holds the entry at row r_reg, column c_reg - 1
    assign equal    = (rdata == key_reg);
    assign greater  = ($signed(rdata) > $signed(key_reg));
    assign c_dec    = c_reg - scms_pkg::COLC_W'(1);

    always_comb
    begin
        r_next = r_reg;
        c_next = c_reg;
        if (greater)
        begin
            c_next = c_dec;
        end
        else
        begin
            r_next = r_reg + scms_pkg::ROWC_W'(1);
        end
    end

    assign walk_end = equal || (c_next == '0) || (r_next == rows);

    // next read: top-right corner on a new search, otherwise the next step
    always_comb
    begin
        if (state_reg == scms_pkg::ST_IDLE)
        begin
            col_sel = cols - scms_pkg::COLC_W'(1);
            raddr   = scms_pkg::addr_of('0, col_sel[scms_pkg::COL_W-1:0]);
        end
        else
        begin
            col_sel = c_next - scms_pkg::COLC_W'(1);
            raddr   = scms_pkg::addr_of(r_next[scms_pkg::ROW_W-1:0],
                                        col_sel[scms_pkg::COL_W-1:0]);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        hit_next   = hit_reg;
        case (state_reg)
            scms_pkg::ST_IDLE:
            begin
                if (search_xfer)
                begin
                    if (rows == '0 || cols == '0)
                    begin
                        hit_next   = 1'b0;
                        state_next = scms_pkg::ST_DONE;
                    end
                    else
                    begin
                        state_next = scms_pkg::ST_WALK;
                    end
                end
            end
            scms_pkg::ST_WALK:
            begin
                if (walk_end)
                begin
                    hit_next   = equal;
                    state_next = scms_pkg::ST_DONE;
                end
            end
            scms_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = scms_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = scms_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= scms_pkg::ST_IDLE;
            row_count_reg    <= '0;
            column_count_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    scms_pkg::REG_ROW_COUNT:    row_count_reg    <= cfg_data;
                    scms_pkg::REG_COLUMN_COUNT: column_count_reg <= cfg_data;
                    default:                    ;
                endcase
            end
            if (state_reg == scms_pkg::ST_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg <= hit_next;
        if (search_xfer)
        begin
            key_reg <= scms_pkg::to_word(item.search_target);
            r_reg   <= '0;
            c_reg   <= cols;
        end
        else if (state_reg == scms_pkg::ST_WALK)
        begin
            r_reg <= r_next;
            c_reg <= c_next;
        end
        if (state_reg == scms_pkg::ST_DONE && out_free)
        begin
            found_reg <= hit_reg;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.found = found_reg;

    // walker stays inside the matrix in use
    a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == scms_pkg::ST_WALK |-> (c_reg != '0) && (r_reg < rows))
        else $error("walk position outside the matrix");

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state register not one-hot");

    a_search_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        search_xfer |=> state_reg != scms_pkg::ST_IDLE)
        else $error("search transfer did not start a walk");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == scms_pkg::ST_DONE))
        else $error("result raised outside the done state");

endmodule

FILE: sim/testbench.sv
// self-checking testbench for the staircase search over a sorted matrix
module testbench;

    localparam longint MIN_VAL = -64'sd2147483648;
    localparam longint MAX_VAL = 64'sd2147483647;
    localparam int ITEM_GOAL   = 1650;
    localparam int SETTLE      = 40;
    localparam int HOLD_CYCLES = 300;

    typedef enum int {FILL_WIDE, FILL_DENSE, FILL_SCATTER} fill_style_t;

    typedef struct {
        logic               cmd;
        logic [3:0]         row;
        logic [3:0]         col;
        logic signed [31:0] value;
        logic signed [31:0] target;
    } cmd_item_t;

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_we;
    logic [scms_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [scms_pkg::CFG_DATA_W-1:0] cfg_data;

    scms_in_if  item_ch ();
    scms_out_if result_ch ();

    staircase_matrix_search u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item_ch),
        .result    (result_ch)
    );

    cmd_item_t item_queue[$];
    logic      found_queue[$];

    // contents and counts as the block sees them, contents updated on each transfer
    scms_pkg::word_t shadow_mtx[scms_pkg::MAX_ROWS][scms_pkg::MAX_COLUMNS];
    logic [4:0]      row_reg;
    logic [4:0]      col_reg;
    // contents the stimulus intends, ahead of the block
    longint          plan_mtx[scms_pkg::MAX_ROWS][scms_pkg::MAX_COLUMNS];

    int  fail_count;
    int  writes_taken;
    int  searches_taken;
    int  hits_seen;
    int  items_total;
    int  settings_used;
    bit  idle_on;
    int  gap_left;
    int  stall_left;
    int  hold_left;
    bit  hold_armed;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("timeout with %0d searches still pending", found_queue.size());
        $display("Regression FAIL");
        $finish;
    end

    task automatic note_failure(input string what, input int want, input int got);
        fail_count++;
        if (fail_count <= 10)
            $display("mismatch: %s expected %0d actual %0d", what, want, got);
    endtask

    // staircase walk from the top-right corner over the current contents
    function automatic logic staircase_walk(input scms_pkg::word_t target);
        int   rows;
        int   cols;
        int   r;
        int   c;
        logic hit;
        rows = (row_reg > scms_pkg::MAX_ROWS) ? scms_pkg::MAX_ROWS : int'(row_reg);
        cols = (col_reg > scms_pkg::MAX_COLUMNS) ? scms_pkg::MAX_COLUMNS : int'(col_reg);
        hit  = 1'b0;
        r    = 0;
        c    = cols;
        while (!hit && r < rows && c > 0)
        begin
            if ($signed(shadow_mtx[r][c-1]) == $signed(target))
                hit = 1'b1;
            else if ($signed(shadow_mtx[r][c-1]) > $signed(target))
                c--;
            else
                r++;
        end
        return hit;
    endfunction

    // driver: presents the head of the queue with random gaps, pops it on transfer
    always @(posedge clk)
    begin : driver
        cmd_item_t head;
        bit        moved;
        if (!rst_n)
        begin
            item_ch.valid <= 1'b0;
            gap_left      <= 0;
        end
        else
        begin
            moved = 1'b0;
            if (item_ch.valid && item_ch.ready)
            begin
                head  = item_queue.pop_front();
                moved = 1'b1;
                if (head.cmd == scms_pkg::CMD_WRITE)
                begin
                    shadow_mtx[head.row][head.col] =
                        scms_pkg::word_t'(longint'(head.value));
                    writes_taken++;
                end
                else
                begin
                    found_queue.push_back(
                        staircase_walk(scms_pkg::word_t'(longint'(head.target))));
                    searches_taken <= searches_taken + 1;
                end
            end
            if (!item_ch.valid || moved)
            begin
                if (gap_left > 0)
                begin
                    item_ch.valid <= 1'b0;
                    gap_left      <= gap_left - 1;
                end
                else if (idle_on && $urandom_range(0, 4) == 0)
                begin
                    item_ch.valid <= 1'b0;
                    gap_left      <= $urandom_range(0, 2);
                end
                else if (item_queue.size() > 0)
                begin
                    item_ch.valid         <= 1'b1;
                    item_ch.cmd           <= item_queue[0].cmd;
                    item_ch.entry_row     <= item_queue[0].row;
                    item_ch.entry_column  <= item_queue[0].col;
                    item_ch.entry_value   <= item_queue[0].value;
                    item_ch.search_target <= item_queue[0].target;
                end
                else
                    item_ch.valid <= 1'b0;
            end
        end
    end

    // one long receiver hold-off once 200 searches went in
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            hold_left  <= 0;
            hold_armed <= 1'b1;
        end
        else if (hold_armed && searches_taken >= 200)
        begin
            hold_left  <= HOLD_CYCLES;
            hold_armed <= 1'b0;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // monitor: checks each result transfer against the oldest prediction
    always @(posedge clk)
    begin : monitor
        logic want;
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            stall_left      <= 0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (found_queue.size() == 0)
                    note_failure("unexpected result, found", -1, int'(result_ch.found));
                else
                begin
                    want = found_queue.pop_front();
                    if (want !== result_ch.found)
                        note_failure("found", int'(want), int'(result_ch.found));
                    else if (want)
                        hits_seen++;
                end
            end
            if (hold_left > 0)
                result_ch.ready <= 1'b0;
            else if (stall_left > 0)
            begin
                result_ch.ready <= 1'b0;
                stall_left      <= stall_left - 1;
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                result_ch.ready <= 1'b0;
                stall_left      <= $urandom_range(0, 2);
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    function automatic longint rand_between(input longint lo, input longint hi);
        longint pick;
        pick = longint'({$urandom(), $urandom()}) & 64'h7FFF_FFFF_FFFF_FFFF;
        return lo + pick % (hi - lo + 1);
    endfunction

    function automatic longint rand_word();
        return rand_between(MIN_VAL, MAX_VAL);
    endfunction

    task automatic push_write(input int r, input int c, input longint v);
        cmd_item_t it;
        plan_mtx[r][c] = v;
        it.cmd    = scms_pkg::CMD_WRITE;
        it.row    = 4'(r);
        it.col    = 4'(c);
        it.value  = 32'(v);
        it.target = 32'($urandom());
        item_queue.push_back(it);
        items_total++;
    endtask

    task automatic push_search(input longint t);
        cmd_item_t it;
        it.cmd    = scms_pkg::CMD_SEARCH;
        it.row    = 4'($urandom());
        it.col    = 4'($urandom());
        it.value  = 32'($urandom());
        it.target = 32'(t);
        item_queue.push_back(it);
        items_total++;
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (item_queue.size() != 0 || found_queue.size() != 0 || item_ch.valid);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic set_dims(input int rows, input int cols);
        wait_idle();
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= scms_pkg::REG_ROW_COUNT;
        cfg_data  <= scms_pkg::CFG_DATA_W'(rows);
        @(posedge clk);
        cfg_index <= scms_pkg::REG_COLUMN_COUNT;
        cfg_data  <= scms_pkg::CFG_DATA_W'(cols);
        @(posedge clk);
        cfg_we  <= 1'b0;
        row_reg = 5'(rows);
        col_reg = 5'(cols);
        settings_used++;
        @(negedge clk);
    endtask

    // largest neighbor above or to the left, so the new entry keeps the order
    function automatic longint floor_of(input int r, input int c);
        longint lo;
        lo = MIN_VAL;
        if (r > 0 && plan_mtx[r-1][c] > lo)
            lo = plan_mtx[r-1][c];
        if (c > 0 && plan_mtx[r][c-1] > lo)
            lo = plan_mtx[r][c-1];
        return lo;
    endfunction

    task automatic fill_matrix(input fill_style_t style);
        longint base;
        longint v;
        base = rand_between(MIN_VAL, MAX_VAL - 100);
        for (int r = 0; r < scms_pkg::MAX_ROWS; r++)
            for (int c = 0; c < scms_pkg::MAX_COLUMNS; c++)
            begin
                case (style)
                    FILL_WIDE:
                    begin
                        if (r == 0 && c == 0)
                            v = MIN_VAL;
                        else if (r == scms_pkg::MAX_ROWS - 1 && c == scms_pkg::MAX_COLUMNS - 1)
                            v = MAX_VAL;
                        else
                            v = floor_of(r, c) + rand_between(0, 64'd134217728);
                    end
                    FILL_DENSE:
                        v = (r == 0 && c == 0) ? base : floor_of(r, c) + rand_between(0, 2);
                    default:
                        v = rand_word();
                endcase
                if (v > MAX_VAL)
                    v = MAX_VAL;
                push_write(r, c, v);
            end
    endtask

    // rewrite one entry with a value that keeps rows and columns sorted
    task automatic push_sorted_update();
        int     r;
        int     c;
        longint lo;
        longint hi;
        r  = $urandom_range(0, scms_pkg::MAX_ROWS - 1);
        c  = $urandom_range(0, scms_pkg::MAX_COLUMNS - 1);
        lo = floor_of(r, c);
        hi = MAX_VAL;
        if (r < scms_pkg::MAX_ROWS - 1 && plan_mtx[r+1][c] < hi)
            hi = plan_mtx[r+1][c];
        if (c < scms_pkg::MAX_COLUMNS - 1 && plan_mtx[r][c+1] < hi)
            hi = plan_mtx[r][c+1];
        push_write(r, c, (lo <= hi) ? rand_between(lo, hi) : lo);
    endtask

    task automatic push_random_search(input int rows, input int cols);
        int     er;
        int     ec;
        int     sel;
        longint t;
        er  = (rows > scms_pkg::MAX_ROWS) ? scms_pkg::MAX_ROWS : rows;
        ec  = (cols > scms_pkg::MAX_COLUMNS) ? scms_pkg::MAX_COLUMNS : cols;
        sel = $urandom_range(0, 9);
        if (er > 0 && ec > 0 && sel < 5)
            t = plan_mtx[$urandom_range(0, er - 1)][$urandom_range(0, ec - 1)];
        else if (er > 0 && ec > 0 && sel < 7)
            t = plan_mtx[$urandom_range(0, er - 1)][$urandom_range(0, ec - 1)]
                + (($urandom_range(0, 1) == 1) ? 1 : -1);
        else if (sel == 7)
            t = ($urandom_range(0, 1) == 1) ? MAX_VAL : MIN_VAL;
        else
            t = rand_word();
        push_search(32'(t));
    endtask

    initial
    begin
        int  rows;
        int  cols;
        int  phase;
        int  count;
        bit  refill;
        fill_style_t style;

        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        row_reg   = '0;
        col_reg   = '0;
        idle_on   = 1'b1;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty matrix straight out of reset
        push_search(MIN_VAL);
        push_search(MAX_VAL);
        fill_matrix(FILL_WIDE);

        set_dims(16, 0);
        push_search(plan_mtx[0][0]);
        set_dims(0, 16);
        push_search(plan_mtx[0][0]);

        set_dims(16, 16);
        push_search(plan_mtx[0][15]);
        push_search(plan_mtx[15][0]);
        push_search(MIN_VAL);
        push_search(MAX_VAL);
        push_search(plan_mtx[7][8]);
        push_search(plan_mtx[7][8] + 1);
        push_search(0);
        push_search(-1);

        // counts above the store size act as the full size; then single-entry and clipped sizes
        set_dims(31, 31);
        push_search(plan_mtx[15][15]);
        push_search(plan_mtx[3][3]);
        set_dims(1, 1);
        push_search(plan_mtx[0][0]);
        push_search(plan_mtx[0][0] + 1);
        set_dims(17, 5);
        push_search(plan_mtx[15][4]);
        push_search(plan_mtx[0][5]);

        phase  = 0;
        refill = 1'b1;
        while (items_total < ITEM_GOAL)
        begin
            case ($urandom_range(0, 9))
                0: begin rows = 0; cols = $urandom_range(0, 31); end
                1: begin rows = $urandom_range(0, 31); cols = 0; end
                2: begin rows = 16; cols = 16; end
                3: begin rows = $urandom_range(17, 31); cols = $urandom_range(17, 31); end
                4: begin rows = 1; cols = $urandom_range(1, 16); end
                5: begin rows = $urandom_range(1, 16); cols = 1; end
                default: begin rows = $urandom_range(1, 16); cols = $urandom_range(1, 16); end
            endcase
            set_dims(rows, cols);
            // quiet tail, and some phases without any idling
            idle_on = (items_total < ITEM_GOAL - 200) && ($urandom_range(0, 3) != 0);
            if (refill || phase % 6 == 5)
            begin
                case ($urandom_range(0, 4))
                    0: style = FILL_SCATTER;
                    1, 2: style = FILL_DENSE;
                    default: style = FILL_WIDE;
                endcase
                fill_matrix(style);
                refill = (style == FILL_SCATTER);
            end
            count = $urandom_range(40, 80);
            for (int i = 0; i < count; i++)
            begin
                case ($urandom_range(0, 19))
                    0: push_write($urandom_range(0, 15), $urandom_range(0, 15), rand_word());
                    1, 2, 3, 4: push_sorted_update();
                    default: push_random_search(rows, cols);
                endcase
            end
            phase++;
        end

        wait_idle();
        if (found_queue.size() != 0)
            note_failure("searches left without result", 0, found_queue.size());
        $display("covered %0d entry writes and %0d searches (%0d found) over %0d size settings",
                 writes_taken, searches_taken, hits_seen, settings_used);
        $display("including empty, single-entry and oversized sizes and one %0d-cycle hold-off",
                 HOLD_CYCLES);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: files.f
design/scms_pkg.sv
design/scms_in_if.sv
design/scms_out_if.sv
design/scms_ram.sv
design/staircase_matrix_search.sv
sim/testbench.sv
